>>> hw/rtl/udprc_pkg.sv
// ----------------------------------------------------------------------------
// UDP receive check package
// Shared constants, verdict codes and the ones-complement fold used by the
// UDP receive checker.
// ----------------------------------------------------------------------------
package udprc_pkg;

  localparam int unsigned NumBindingsDefault = 4;
  localparam int unsigned MaxBindings        = 4;
  localparam int unsigned SlotW              = 2;
  localparam int unsigned PortW              = 16;

  localparam logic [15:0] UdpProto   = 16'd17;
  localparam logic [15:0] HdrBytes   = 16'd8;
  localparam logic [15:0] CountMax   = 16'hFFFF;
  localparam logic [15:0] SumAllOnes = 16'hFFFF;

  // Byte offsets of the odd (low) half of each header word.
  localparam logic [2:0] OffSrcPort  = 3'd1;
  localparam logic [2:0] OffDstPort  = 3'd3;
  localparam logic [2:0] OffLength   = 3'd5;
  localparam logic [2:0] OffChecksum = 3'd7;
  localparam logic [15:0] OffSummedHdr = 16'd6;

  typedef enum logic [2:0] {
    DropNone     = 3'd0,
    DropShort    = 3'd1,
    DropZeroPort = 3'd2,
    DropBadLen   = 3'd3,
    DropChecksum = 3'd4,
    DropUnbound  = 3'd5
  } drop_e;

  // Registered input beat, with the pseudo-header partial sum folded in.
  typedef struct packed {
    logic [7:0]  data;
    logic        first;
    logic        last;
    logic [31:0] src_ip;
    logic [15:0] ph_sum;
  } beat_t;

  // End-around carry fold of a wide sum. A nonzero sum never folds to zero.
  function automatic logic [15:0] fold19(input logic [18:0] t);
    logic [16:0] f1;
    logic [16:0] f2;
    f1 = {1'b0, t[15:0]} + {14'd0, t[18:16]};
    f2 = {1'b0, f1[15:0]} + {16'd0, f1[16]};
    return f2[15:0];
  endfunction

endpackage

>>> hw/rtl/udp_receive_check_demux_core.sv
// ----------------------------------------------------------------------------
// UDP receive check and port demultiplexer
// Parses a UDP segment one byte per beat, verifies the checksum over the
// pseudo-header and the segment, and gives one verdict on the last byte.
// ----------------------------------------------------------------------------
// The block takes one segment byte per clock cycle while in_stall_o is low. A
// byte goes through an input register, then updates the parse state (byte count,
// header fields, ones-complement sum); the verdict is formed combinationally from
// that state and lands in the output register, so a result passes the input
// register, the parse state and the output register in that order. A verdict that
// cannot leave because the output is stalled waits with the parse state frozen,
// while the input register still takes one more byte. Port slots are written
// through the configuration channel, which is always ready; write them only
// while no segment is in flight.
module udp_receive_check_demux_core #(
  parameter int unsigned NUM_BINDINGS = udprc_pkg::NumBindingsDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Configuration writes
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [udprc_pkg::SlotW-1:0] cfg_index_i,
  input  logic [udprc_pkg::PortW-1:0] cfg_data_i,
  // Byte input
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [7:0]                 data_byte_i,
  input  logic                       first_byte_i,
  input  logic                       last_byte_i,
  input  logic [31:0]                source_ip_i,
  input  logic [31:0]                destination_ip_i,
  // Verdict output
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       accepted_o,
  output logic [2:0]                 drop_reason_o,
  output logic [udprc_pkg::SlotW-1:0] binding_slot_o,
  output logic [31:0]                sender_ip_o,
  output logic [15:0]                sender_port_o,
  output logic [15:0]                target_port_o,
  output logic [15:0]                payload_length_o
);
  import udprc_pkg::*;

  // Configuration
  logic [PortW-1:0] port_slot_q [NUM_BINDINGS];

  // Pipeline control
  logic  in_accept;
  logic  a_valid_q, a_valid_d;
  logic  a_adv;
  logic  b_pend_q, b_pend_d;
  logic  b_adv;
  beat_t a_q, a_d;

  // Parse state
  logic [15:0] byte_count_q, byte_count_d;
  logic [15:0] running_sum_q, running_sum_d;
  logic [7:0]  pending_q, pending_d;
  logic [15:0] hdr_sport_q, hdr_sport_d;
  logic [15:0] hdr_dport_q, hdr_dport_d;
  logic [15:0] hdr_len_q, hdr_len_d;
  logic [15:0] hdr_csum_q, hdr_csum_d;
  logic [31:0] saved_ip_q, saved_ip_d;

  // Parse datapath
  logic [15:0] idx;
  logic [15:0] hl_cur;
  logic [7:0]  pend_cur;
  logic [15:0] word;
  logic [15:0] sum_base;
  logic [15:0] len_add;
  logic [15:0] byte_add;
  logic [17:0] sum_total;

  // Verdict
  drop_e              reason;
  logic [SlotW-1:0]   slot_sel;
  logic               slot_hit;
  logic [15:0]        vd_sport, vd_dport, vd_plen;

  // Output register
  logic               out_valid_q, out_valid_d;
  logic               accepted_q;
  logic [2:0]         reason_q;
  logic [SlotW-1:0]   slot_q;
  logic [31:0]        sender_ip_q;
  logic [15:0]        sport_q, dport_q, plen_q;

  // ---------------------------------------------------------------------------
  // Handshakes
  // ---------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  assign b_adv      = b_pend_q && (!out_valid_q || !out_stall_i);
  assign a_adv      = a_valid_q && (!b_pend_q || b_adv);
  assign in_stall_o = a_valid_q && !a_adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    a_valid_d = a_valid_q;
    if (in_accept) begin
      a_valid_d = 1'b1;
    end else if (a_adv) begin
      a_valid_d = 1'b0;
    end

    b_pend_d = b_pend_q;
    if (a_adv) begin
      b_pend_d = a_q.last;
    end else if (b_adv) begin
      b_pend_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (b_adv) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Input register; the address and protocol part of the pseudo-header sum is folded here.
  always_comb begin
    a_d.data   = data_byte_i;
    a_d.first  = first_byte_i;
    a_d.last   = last_byte_i;
    a_d.src_ip = source_ip_i;
    a_d.ph_sum = fold19({3'd0, source_ip_i[31:16]} + {3'd0, source_ip_i[15:0]}
                      + {3'd0, destination_ip_i[31:16]}
                      + {3'd0, destination_ip_i[15:0]} + {3'd0, UdpProto});
  end

  // ---------------------------------------------------------------------------
  // Parse state update
  // ---------------------------------------------------------------------------
  always_comb begin
    idx      = a_q.first ? 16'd0 : byte_count_q;
    hl_cur   = a_q.first ? 16'd0 : hdr_len_q;
    pend_cur = a_q.first ? 8'd0  : pending_q;
    sum_base = a_q.first ? a_q.ph_sum : running_sum_q;
    word     = {pend_cur, a_q.data};

    pending_d   = pend_cur;
    hdr_sport_d = a_q.first ? 16'd0 : hdr_sport_q;
    hdr_dport_d = a_q.first ? 16'd0 : hdr_dport_q;
    hdr_len_d   = hl_cur;
    hdr_csum_d  = a_q.first ? 16'd0 : hdr_csum_q;
    saved_ip_d  = a_q.first ? a_q.src_ip : saved_ip_q;
    len_add     = 16'd0;

    if (idx < HdrBytes) begin
      if (!idx[0]) begin
        pending_d = a_q.data;
      end else begin
        unique case (idx[2:0])
          OffSrcPort: hdr_sport_d = word;
          OffDstPort: hdr_dport_d = word;
          OffLength: begin
            hdr_len_d = word;
            len_add   = word;
          end
          OffChecksum: hdr_csum_d = word;
          default: ;
        endcase
      end
    end

    // The first six header bytes are always summed; later bytes, the checksum included, only up to the length field.
    if (idx < OffSummedHdr || idx < hl_cur) begin
      byte_add = idx[0] ? {8'd0, a_q.data} : {a_q.data, 8'd0};
    end else begin
      byte_add = 16'd0;
    end

    sum_total     = {2'd0, sum_base} + {2'd0, len_add} + {2'd0, byte_add};
    running_sum_d = fold19({1'b0, sum_total});
    byte_count_d  = (idx == CountMax) ? idx : idx + 16'd1;
  end

  // ---------------------------------------------------------------------------
  // Verdict from the parse state left by the last byte
  // ---------------------------------------------------------------------------
  always_comb begin
    slot_hit = 1'b0;
    slot_sel = '0;
    // Walk downward so the lowest matching slot wins.
    for (int i = NUM_BINDINGS - 1; i >= 0; i--) begin
      if (port_slot_q[i] != 16'd0 && port_slot_q[i] == hdr_dport_q) begin
        slot_hit = 1'b1;
        slot_sel = SlotW'(i);
      end
    end

    vd_sport = hdr_sport_q;
    vd_dport = hdr_dport_q;
    vd_plen  = 16'd0;
    priority if (byte_count_q < HdrBytes) begin
      reason   = DropShort;
      vd_sport = 16'd0;
      vd_dport = 16'd0;
    end else if (hdr_sport_q == 16'd0 || hdr_dport_q == 16'd0) begin
      reason = DropZeroPort;
    end else if (hdr_len_q < HdrBytes || hdr_len_q > byte_count_q) begin
      reason = DropBadLen;
    end else begin
      vd_plen = hdr_len_q - HdrBytes;
      // A received checksum of zero means the sender did not compute one.
      if (hdr_csum_q != 16'd0 && running_sum_q != SumAllOnes) begin
        reason = DropChecksum;
      end else if (slot_hit) begin
        reason = DropNone;
      end else begin
        reason = DropUnbound;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BINDINGS; i++) begin
        port_slot_q[i] <= '0;
      end
    end else if (cfg_valid_i && cfg_ready_o) begin
      for (int i = 0; i < NUM_BINDINGS; i++) begin
        if (cfg_index_i == SlotW'(i)) begin
          port_slot_q[i] <= cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_pend_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      a_valid_q   <= a_valid_d;
      b_pend_q    <= b_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      a_q <= a_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q  <= '0;
      running_sum_q <= '0;
      pending_q     <= '0;
      hdr_sport_q   <= '0;
      hdr_dport_q   <= '0;
      hdr_len_q     <= '0;
      hdr_csum_q    <= '0;
      saved_ip_q    <= '0;
    end else if (a_adv) begin
      byte_count_q  <= byte_count_d;
      running_sum_q <= running_sum_d;
      pending_q     <= pending_d;
      hdr_sport_q   <= hdr_sport_d;
      hdr_dport_q   <= hdr_dport_d;
      hdr_len_q     <= hdr_len_d;
      hdr_csum_q    <= hdr_csum_d;
      saved_ip_q    <= saved_ip_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_adv) begin
      accepted_q  <= (reason == DropNone);
      reason_q    <= reason;
      slot_q      <= (reason == DropNone) ? slot_sel : '0;
      sender_ip_q <= saved_ip_q;
      sport_q     <= vd_sport;
      dport_q     <= vd_dport;
      plen_q      <= vd_plen;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign accepted_o       = accepted_q;
  assign drop_reason_o    = reason_q;
  assign binding_slot_o   = slot_q;
  assign sender_ip_o      = sender_ip_q;
  assign sender_port_o    = sport_q;
  assign target_port_o    = dport_q;
  assign payload_length_o = plen_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
`ifndef SYNTHESIS
  a_accept_matches_reason : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (accepted_o == (drop_reason_o == DropNone)))
    else $error("accepted flag disagrees with drop reason");

  a_short_clears_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && drop_reason_o == DropShort |->
      sender_port_o == 16'd0 && target_port_o == 16'd0 && payload_length_o == 16'd0)
    else $error("short segment verdict carries header fields");

  a_state_frozen_on_pending : assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_pend_q && !b_adv |=> b_pend_q && $stable(byte_count_q) && $stable(running_sum_q))
    else $error("parse state changed while a verdict was pending");
`endif

endmodule

>>> verif/udp_receive_check_demux_core_tb.sv
// ----------------------------------------------------------------------------
// UDP receive check and port demultiplexer testbench
// Sends UDP segments one byte per beat and predicts each verdict from the
// parsed header, the ones-complement sum and the bound ports. Every verdict
// beat is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module udp_receive_check_demux_core_tb;
  import udprc_pkg::*;

  typedef enum logic [1:0] {
    RegPortSlot0 = 2'd0,
    RegPortSlot1 = 2'd1,
    RegPortSlot2 = 2'd2,
    RegPortSlot3 = 2'd3
  } port_reg_e;

  typedef enum int {
    CsumGood,
    CsumZero,
    CsumBad
  } csum_mode_e;

  typedef struct packed {
    logic        accepted;
    drop_e       reason;
    logic [1:0]  slot;
    logic [31:0] ip;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [15:0] plen;
  } verdict_t;

  // Tracks the parse of the byte stream and holds the verdicts still owed.
  class verdict_scoreboard;
    logic [15:0] port_slot [4];
    logic [15:0] byte_cnt;
    logic [15:0] csum;
    logic [7:0]  hi_byte;
    logic [15:0] hdr_sport;
    logic [15:0] hdr_dport;
    logic [15:0] hdr_len;
    logic [15:0] hdr_csum;
    logic [31:0] src_ip;
    verdict_t    verdict_q [$];
    int unsigned errors;

    function new();
      foreach (port_slot[i]) port_slot[i] = '0;
      clear_parse();
      src_ip = '0;
      errors = 0;
    endfunction

    static function logic [15:0] oc_add(logic [15:0] a, logic [15:0] w);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, w};
      return s[15:0] + {15'd0, s[16]};
    endfunction

    function void clear_parse();
      byte_cnt  = '0;
      csum      = '0;
      hi_byte   = '0;
      hdr_sport = '0;
      hdr_dport = '0;
      hdr_len   = '0;
      hdr_csum  = '0;
    endfunction

    function void note_byte(logic [7:0] b, logic f, logic l, logic [31:0] sip,
                            logic [31:0] dip);
      logic [15:0] idx;
      logic [15:0] w;
      verdict_t    v;
      if (f) begin
        clear_parse();
        src_ip = sip;
        csum = oc_add(csum, sip[31:16]);
        csum = oc_add(csum, sip[15:0]);
        csum = oc_add(csum, dip[31:16]);
        csum = oc_add(csum, dip[15:0]);
        csum = oc_add(csum, UdpProto);
      end
      idx = byte_cnt;
      if (idx < HdrBytes) begin
        if (!idx[0]) begin
          hi_byte = b;
        end else begin
          w = {hi_byte, b};
          case (idx[2:0])
            OffSrcPort: hdr_sport = w;
            OffDstPort: hdr_dport = w;
            OffLength: begin
              // The length field also belongs to the pseudo-header.
              hdr_len = w;
              csum = oc_add(csum, w);
            end
            default: hdr_csum = w;
          endcase
        end
      end
      if (idx < OffSummedHdr || idx < hdr_len) begin
        csum = oc_add(csum, idx[0] ? {8'h00, b} : {b, 8'h00});
      end
      if (byte_cnt != CountMax) byte_cnt++;
      if (!l) return;

      v = '0;
      v.reason = DropNone;
      v.ip = src_ip;
      if (byte_cnt < HdrBytes) begin
        v.reason = DropShort;
      end else begin
        v.sport = hdr_sport;
        v.dport = hdr_dport;
        if (hdr_sport == '0 || hdr_dport == '0) begin
          v.reason = DropZeroPort;
        end else if (hdr_len < HdrBytes || hdr_len > byte_cnt) begin
          v.reason = DropBadLen;
        end else begin
          v.plen = hdr_len - HdrBytes;
          if (hdr_csum != '0 && csum != SumAllOnes) begin
            v.reason = DropChecksum;
          end else begin
            v.reason = DropUnbound;
            // Scan downward so that the lowest matching slot is kept.
            for (int i = NumBindingsDefault - 1; i >= 0; i--) begin
              if (port_slot[i] != '0 && port_slot[i] == hdr_dport) begin
                v.reason = DropNone;
                v.slot = 2'(i);
              end
            end
          end
        end
      end
      v.accepted = (v.reason == DropNone);
      verdict_q.push_back(v);
    endfunction

    function void compare(string name, logic [31:0] e, logic [31:0] a);
      if (a !== e) begin
        $error("%s: expected %0h, got %0h", name, e, a);
        errors++;
      end
    endfunction

    function void check_verdict(verdict_t got);
      verdict_t e;
      if (verdict_q.size() == 0) begin
        $error("verdict beat with none outstanding: reason %0d port %0h",
               got.reason, got.dport);
        errors++;
        return;
      end
      e = verdict_q.pop_front();
      compare("accepted", e.accepted, got.accepted);
      compare("drop_reason", e.reason, got.reason);
      compare("binding_slot", e.slot, got.slot);
      compare("sender_ip", e.ip, got.ip);
      compare("sender_port", e.sport, got.sport);
      compare("target_port", e.dport, got.dport);
      compare("payload_length", e.plen, got.plen);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [15:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic        first_byte_i;
  logic        last_byte_i;
  logic [31:0] source_ip_i;
  logic [31:0] destination_ip_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        accepted_o;
  logic [2:0]  drop_reason_o;
  logic [1:0]  binding_slot_o;
  logic [31:0] sender_ip_o;
  logic [15:0] sender_port_o;
  logic [15:0] target_port_o;
  logic [15:0] payload_length_o;

  verdict_scoreboard sb = new();
  logic [7:0] seg [$];
  int unsigned bytes_sent = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit hold_start = 1'b0;

  udp_receive_check_demux_core u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .first_byte_i    (first_byte_i),
    .last_byte_i     (last_byte_i),
    .source_ip_i     (source_ip_i),
    .destination_ip_i(destination_ip_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .accepted_o      (accepted_o),
    .drop_reason_o   (drop_reason_o),
    .binding_slot_o  (binding_slot_o),
    .sender_ip_o     (sender_ip_o),
    .sender_port_o   (sender_port_o),
    .target_port_o   (target_port_o),
    .payload_length_o(payload_length_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  initial begin
    #60000000;
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        sb.note_byte(data_byte_i, first_byte_i, last_byte_i, source_ip_i,
                     destination_ip_i);
      end
      if (out_valid_o && !out_stall_i) begin
        sb.check_verdict('{accepted_o, drop_e'(drop_reason_o), binding_slot_o,
                           sender_ip_o, sender_port_o, target_port_o,
                           payload_length_o});
      end
    end
  end

  // Verdict side: random stalls, or a long hold-off when one is requested.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_start) begin
        hold_start = 1'b0;
        hold_left = 400;
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  function automatic logic [31:0] rand_ip();
    case ($urandom_range(7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_dport();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 6) return sb.port_slot[$urandom_range(3)];
    if (r == 6) return 16'hFFFF;
    if (r == 7) return 16'h0001;
    return 16'($urandom);
  endfunction

  task automatic write_port(port_reg_e r, logic [15:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= r;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.port_slot[r] = v;
    @(negedge clk_i);
  endtask

  task automatic bind_ports(logic [15:0] p0, logic [15:0] p1, logic [15:0] p2,
                            logic [15:0] p3);
    write_port(RegPortSlot0, p0);
    write_port(RegPortSlot1, p1);
    write_port(RegPortSlot2, p2);
    write_port(RegPortSlot3, p3);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_byte(logic [7:0] b, logic f, logic l, logic [31:0] sip,
                           logic [31:0] dip);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    first_byte_i <= f;
    last_byte_i <= l;
    source_ip_i <= sip;
    destination_ip_i <= dip;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  // Fills seg with a segment of n bytes whose header carries len_field. A good
  // checksum covers the pseudo-header and the first max(6, len_field) bytes.
  task automatic build_segment(logic [31:0] sip, logic [31:0] dip,
                               logic [15:0] sport, logic [15:0] dport,
                               int len_field, int n, csum_mode_e mode);
    logic [15:0] hdr [3];
    logic [15:0] sum;
    logic [15:0] c;
    hdr[0] = sport;
    hdr[1] = dport;
    hdr[2] = 16'(len_field);
    seg.delete();
    for (int i = 0; i < n; i++) begin
      if (i < 6) seg.push_back(i[0] ? hdr[i / 2][7:0] : hdr[i / 2][15:8]);
      else if (i < 8) seg.push_back(8'h00);
      else seg.push_back(8'($urandom));
    end
    sum = '0;
    sum = verdict_scoreboard::oc_add(sum, sip[31:16]);
    sum = verdict_scoreboard::oc_add(sum, sip[15:0]);
    sum = verdict_scoreboard::oc_add(sum, dip[31:16]);
    sum = verdict_scoreboard::oc_add(sum, dip[15:0]);
    sum = verdict_scoreboard::oc_add(sum, UdpProto);
    sum = verdict_scoreboard::oc_add(sum, 16'(len_field));
    for (int i = 0; i < n; i++) begin
      if (i < 6 || i < len_field) begin
        sum = verdict_scoreboard::oc_add(sum, i[0] ? {8'h00, seg[i]} : {seg[i], 8'h00});
      end
    end
    c = ~sum;
    if (mode == CsumZero) c = '0;
    else if (mode == CsumBad) c = c ^ 16'($urandom_range(1, 65535));
    if (n > 6) seg[6] = c[15:8];
    if (n > 7) seg[7] = c[7:0];
  endtask

  task automatic send_segment(logic [31:0] sip, logic [31:0] dip, logic with_first,
                              logic with_last);
    foreach (seg[i]) begin
      send_byte(seg[i], with_first && i == 0, with_last && i == seg.size() - 1,
                sip, dip);
    end
  endtask

  task automatic random_segment();
    logic [31:0] sip;
    logic [31:0] dip;
    logic [15:0] sport;
    logic [15:0] dport;
    int          n;
    int          len;
    int          kind;
    int unsigned r;
    csum_mode_e  mode;
    sip = rand_ip();
    dip = rand_ip();
    sport = 16'($urandom_range(1, 65535));
    dport = pick_dport();
    n = 8 + (($urandom_range(19) == 0) ? $urandom_range(100, 600) : $urandom_range(24));
    r = $urandom_range(9);
    mode = (r < 8) ? CsumGood : (r == 8) ? CsumZero : CsumBad;
    kind = $urandom_range(99);
    if (kind < 70) begin
      build_segment(sip, dip, sport, dport, n, n, mode);
      send_segment(sip, dip, 1'b1, 1'b1);
    end else if (kind < 76) begin
      // Trailing bytes past the length field are counted but not summed.
      build_segment(sip, dip, sport, dport, n, n + $urandom_range(1, 6), mode);
      send_segment(sip, dip, 1'b1, 1'b1);
    end else if (kind < 80) begin
      len = ($urandom_range(2) == 0) ? $urandom_range(7) : n + $urandom_range(1, 1000);
      build_segment(sip, dip, sport, dport, len, n, mode);
      send_segment(sip, dip, 1'b1, 1'b1);
    end else if (kind < 84) begin
      if ($urandom_range(1) == 0) sport = '0;
      else dport = '0;
      build_segment(sip, dip, sport, dport, n, n, mode);
      send_segment(sip, dip, 1'b1, 1'b1);
    end else if (kind < 88) begin
      build_segment(sip, dip, sport, dport, n, $urandom_range(1, 7), mode);
      send_segment(sip, dip, 1'b1, 1'b1);
    end else if (kind < 93) begin
      repeat ($urandom_range(1, 10)) begin
        send_byte(8'($urandom), $urandom_range(4) == 0, $urandom_range(4) == 0,
                  rand_ip(), rand_ip());
      end
    end else if (kind < 97) begin
      // Abandoned segment: the next first byte restarts the parse.
      build_segment(sip, dip, sport, dport, n, n, mode);
      send_segment(sip, dip, 1'b1, 1'b0);
    end else begin
      build_segment(sip, dip, sport, dport, n, n, mode);
      send_segment(sip, dip, 1'b0, 1'b1);
    end
  endtask

  task automatic run_random(int unsigned target);
    while (bytes_sent < target) random_segment();
  endtask

  // Drains owed verdicts, then gives the pipeline time to empty.
  task automatic settle();
    int unsigned waited;
    waited = 0;
    in_valid_i <= 1'b0;
    while (sb.verdict_q.size() != 0 && waited < 200000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (10) @(negedge clk_i);
  endtask

  initial begin
    int unsigned base;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = RegPortSlot0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    data_byte_i = '0;
    first_byte_i = 1'b0;
    last_byte_i = 1'b0;
    source_ip_i = '0;
    destination_ip_i = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct = 14;
    recv_stall_pct = 88;

    // Bytes before any segment start continue the reset parse state.
    build_segment(32'h0A00_0001, 32'h0A00_0002, 16'h1234, 16'h0035, 8, 8, CsumGood);
    send_segment(32'h0A00_0001, 32'h0A00_0002, 1'b0, 1'b1);
    send_byte(8'hFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    settle();
    bind_ports(16'h0035, 16'hFFFF, 16'h0035, 16'h0001);
    build_segment(32'hFFFF_FFFF, 32'h0000_0000, 16'hFFFF, 16'h0035, 8, 8, CsumGood);
    send_segment(32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1);
    build_segment(32'h0000_0000, 32'hFFFF_FFFF, 16'h0001, 16'h0001, 9, 9, CsumZero);
    send_segment(32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1);
    settle();

    run_random(bytes_sent + 400);
    settle();
    bind_ports(16'h0000, 16'h1234, 16'hFFFF, 16'h1234);

    send_idle_pct = 88;
    recv_stall_pct = 14;
    run_random(bytes_sent + 400);
    settle();
    bind_ports(16'($urandom_range(1, 65535)), 16'h0000, 16'h8000,
               16'($urandom_range(1, 65535)));

    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_start = 1'b1;
    repeat (8) random_segment();
    base = bytes_sent;
    run_random(base + 200);
    settle();

    if (sb.verdict_q.size() != 0) begin
      $error("%0d verdicts never arrived", sb.verdict_q.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/udprc_pkg.sv
hw/rtl/udp_receive_check_demux_core.sv
verif/udp_receive_check_demux_core_tb.sv
